FILE: design/tlqs_pkg.sv
// ----------------------------------------------------------------------------
// tlqs_pkg
// shared constants and types for the two-level queue scheduler core
// ----------------------------------------------------------------------------
package tlqs_pkg;

	localparam int MaxProcs = 16;
	localparam int IdxW     = $clog2(MaxProcs);
	localparam int CntW     = IdxW + 1;
	localparam int TimeW    = 22;

	localparam logic [7:0] HighQuantumRst = 8'd4;
	localparam logic [7:0] LowQuantumRst  = 8'd3;

	localparam logic CfgHighQuantum = 1'b0;
	localparam logic CfgLowQuantum  = 1'b1;

	typedef logic [IdxW-1:0] idx_t;
	typedef logic [CntW-1:0] cnt_t;

	// one process record as held in the process memory
	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] burst;
		logic        level;
		logic [15:0] remain;
	} proc_t;

	// memory access request from the sequencer
	typedef struct packed {
		logic  rd_en;
		idx_t  rd_addr;
		logic  wr_en;
		idx_t  wr_addr;
		proc_t wr_data;
	} mem_req_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_ZERO_RD,
		ST_ZERO_CHK,
		ST_TICK,
		ST_ADM_RD,
		ST_ADM_CHK,
		ST_REQUEUE,
		ST_PICK,
		ST_RUN_CHK,
		ST_LOW_STEP,
		ST_LOW_COMMIT,
		ST_OUT_RD,
		ST_OUT_EMIT
	} state_t;

endpackage

FILE: design/two_level_queue_scheduler_sim_core.sv
// ----------------------------------------------------------------------------
// two_level_queue_scheduler_sim_core
// loads processes, then steps a two-level queue schedule tick by tick and
// reports waiting and turnaround time per process
// ----------------------------------------------------------------------------
// channel  | direction | handshake            | payload
// load     | in        | start / busy         | arrival_time burst_length low_level is_final
// result   | out       | result_valid (strobe)| process_index wait_time turnaround_time last_result
// config   | in        | cfg_valid / cfg_ready| cfg_index cfg_data
//
// a non-final load only stores its record; the final load runs the schedule: a
// zero-burst pass, then each loop pass has a top-of-loop state, an admission
// scan over the process memory, a read and a pick step per pending requeue
// and for the pick, plus a run check for a high slice; an idle tick is one such
// pass, and each low-level tick adds another admission scan plus a step and a commit
// then n results, each emitted in the state after its memory reads
// reset clears counters, queues and marks, quanta go to 4 and 3; memories are not cleared
// results cannot be stalled, the receiver takes each strobe
// ----------------------------------------------------------------------------
module two_level_queue_scheduler_sim_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] arrival_time,
	input  logic [15:0] burst_length,
	input  logic        low_level,
	input  logic        is_final,
	output logic        result_valid,
	output logic [5:0]  process_index,
	output logic [21:0] wait_time,
	output logic [21:0] turnaround_time,
	output logic        last_result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);
	import tlqs_pkg::*;

	state_t state_q, state_d;

	logic [7:0]       hq_q, lq_q;
	cnt_t             load_cnt_q, done_cnt_q;
	logic [TimeW-1:0] clock_q;
	logic [MaxProcs-1:0] mark_q;
	idx_t             scan_q;       // scan / output pointer
	idx_t             run_high_q, run_low_q, cur_q;
	logic             high_pend_q, low_pend_q;
	logic [7:0]       step_q;       // low-level ticks taken in this slice
	logic             in_low_q;     // admission scan is inside a low slice
	logic             mark_d_set;

	mem_req_t req;
	proc_t    rd;
	logic             wwr;
	idx_t             wwa, wra;
	logic [TimeW-1:0] wwd, wrd;

	logic hf_push, hf_pop, hf_ne, lf_push, lf_pop, lf_ne, fclr;
	idx_t hf_pi, hf_head, lf_pi, lf_head;

	tlqs_proc_mem u_pmem (.clk(clk), .req(req), .rd_data(rd));
	tlqs_wait_mem u_wmem (.clk(clk), .wr_en(wwr), .wr_addr(wwa), .wr_data(wwd),
		.rd_addr(wra), .rd_data(wrd));
	tlqs_fifo u_hf (.clk(clk), .arst_n(arst_n), .clr(fclr), .push(hf_push),
		.push_idx(hf_pi), .pop(hf_pop), .head_idx(hf_head), .not_empty(hf_ne));
	tlqs_fifo u_lf (.clk(clk), .arst_n(arst_n), .clr(fclr), .push(lf_push),
		.push_idx(lf_pi), .pop(lf_pop), .head_idx(lf_head), .not_empty(lf_ne));

	assign busy      = (state_q != ST_LOAD);
	assign cfg_ready = (state_q == ST_LOAD);

	// effective quanta, zero acts as one
	logic [7:0] hq_eff, lq_eff;
	assign hq_eff = (hq_q == '0) ? 8'd1 : hq_q;
	assign lq_eff = (lq_q == '0) ? 8'd1 : lq_q;

	// finishing arithmetic: clock minus (burst + arrival), clamped
	logic [TimeW-1:0] fin_clock, used, fin_wait;
	assign used     = TimeW'(rd.burst) + TimeW'(rd.arrival);
	assign fin_wait = (fin_clock >= used) ? fin_clock - used : '0;

	// high slice outcome
	logic [15:0] h_take;
	assign h_take = (rd.remain >= 16'(hq_eff)) ? 16'(hq_eff) : rd.remain;

	logic last_scan;
	assign last_scan = (cnt_t'(scan_q) + cnt_t'(1) >= load_cnt_q);

	logic load_fire;
	assign load_fire = start && !busy;

	logic [TimeW-1:0] clock_d;
	cnt_t done_d;
	idx_t scan_d, run_high_d, run_low_d, cur_d;
	logic high_pend_d, low_pend_d, in_low_d, clr_batch;
	logic [7:0] step_d;

	always_comb begin
		state_d     = state_q;
		clock_d     = clock_q;
		done_d      = done_cnt_q;
		scan_d      = scan_q;
		run_high_d  = run_high_q;
		run_low_d   = run_low_q;
		cur_d       = cur_q;
		high_pend_d = high_pend_q;
		low_pend_d  = low_pend_q;
		in_low_d    = in_low_q;
		step_d      = step_q;
		clr_batch   = 1'b0;
		mark_d_set  = 1'b0;
		req         = '0;
		wwr = 1'b0; wwa = cur_q; wwd = '0; wra = scan_q;
		hf_push = 1'b0; hf_pi = scan_q; hf_pop = 1'b0;
		lf_push = 1'b0; lf_pi = scan_q; lf_pop = 1'b0;
		fin_clock = clock_q;
		result_valid = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (load_fire) begin
					if (load_cnt_q != cnt_t'(MaxProcs)) begin
						req.wr_en   = 1'b1;
						req.wr_addr = load_cnt_q[IdxW-1:0];
						req.wr_data = '{arrival_time, burst_length, low_level, burst_length};
					end
					if (is_final) begin
						scan_d  = '0;
						state_d = ST_ZERO_RD;
					end
				end
			end
			ST_ZERO_RD: begin
				if (load_cnt_q == '0) begin
					state_d = ST_OUT_RD;
				end else begin
					req.rd_en = 1'b1; req.rd_addr = scan_q;
					state_d = ST_ZERO_CHK;
				end
			end
			ST_ZERO_CHK: begin
				if (rd.remain == '0) begin
					wwr = 1'b1; wwa = scan_q; wwd = '0;
					done_d = done_cnt_q + cnt_t'(1);
				end
				if (last_scan) begin
					state_d = ST_TICK;
				end else begin
					scan_d = scan_q + idx_t'(1);
					state_d = ST_ZERO_RD;
				end
			end
			ST_TICK: begin
				// top of the main loop
				if (done_cnt_q >= load_cnt_q) begin
					scan_d = '0; state_d = ST_OUT_RD;
				end else begin
					scan_d = '0; in_low_d = 1'b0; state_d = ST_ADM_RD;
				end
			end
			ST_ADM_RD: begin
				req.rd_en = 1'b1; req.rd_addr = scan_q;
				state_d = ST_ADM_CHK;
			end
			ST_ADM_CHK: begin
				if (TimeW'(rd.arrival) <= clock_q && rd.remain != '0 && !mark_q[scan_q]) begin
					mark_d_set = 1'b1;
					if (rd.level) lf_push = 1'b1; else hf_push = 1'b1;
				end
				if (last_scan) begin
					state_d = in_low_q ? ST_LOW_STEP : ST_REQUEUE;
				end else begin
					scan_d = scan_q + idx_t'(1);
					state_d = ST_ADM_RD;
				end
			end
			ST_REQUEUE: begin
				// pending requeues need remaining of the last runner
				req.rd_en = 1'b1;
				req.rd_addr = high_pend_q ? run_high_q : run_low_q;
				state_d = ST_PICK;
			end
			ST_PICK: begin
				if (high_pend_q) begin
					high_pend_d = 1'b0;
					if (rd.remain != '0) begin hf_push = 1'b1; hf_pi = run_high_q; end
					state_d = ST_REQUEUE;
				end else if (low_pend_q) begin
					low_pend_d = 1'b0;
					if (rd.remain != '0) begin lf_push = 1'b1; lf_pi = run_low_q; end
					state_d = ST_REQUEUE;
				end else if (hf_ne) begin
					hf_pop = 1'b1; cur_d = hf_head; run_high_d = hf_head;
					high_pend_d = 1'b1;
					req.rd_en = 1'b1; req.rd_addr = hf_head;
					in_low_d = 1'b0;
					state_d = ST_RUN_CHK;
				end else if (lf_ne) begin
					lf_pop = 1'b1; cur_d = lf_head; run_low_d = lf_head;
					low_pend_d = 1'b1; step_d = '0;
					in_low_d = 1'b1;
					scan_d = '0;
					state_d = ST_ADM_RD;
				end else begin
					clock_d = clock_q + TimeW'(1);
					state_d = ST_TICK;
				end
			end
			ST_RUN_CHK: begin
				// high slice on the record just read
				fin_clock = clock_q + TimeW'(h_take);
				clock_d = fin_clock;
				req.wr_en = 1'b1; req.wr_addr = cur_q;
				req.wr_data = '{rd.arrival, rd.burst, rd.level, rd.remain - h_take};
				if (rd.remain == h_take) begin
					wwr = 1'b1; wwa = cur_q; wwd = fin_wait;
					done_d = done_cnt_q + cnt_t'(1);
				end
				state_d = ST_TICK;
			end
			ST_LOW_STEP: begin
				// admission scan done for this low tick; current record needed
				if (hf_ne) begin
					state_d = ST_TICK;
				end else begin
					req.rd_en = 1'b1; req.rd_addr = cur_q;
					in_low_d = 1'b0;
					state_d = ST_LOW_COMMIT;
				end
			end
			ST_LOW_COMMIT: begin
				// one low-level tick on the record just read
				fin_clock = clock_q + TimeW'(1);
				clock_d = fin_clock;
				req.wr_en = 1'b1; req.wr_addr = cur_q;
				req.wr_data = '{rd.arrival, rd.burst, rd.level, rd.remain - 16'd1};
				step_d = step_q + 8'd1;
				if (rd.remain == 16'd1) begin
					wwr = 1'b1; wwa = cur_q; wwd = fin_wait;
					done_d = done_cnt_q + cnt_t'(1);
					state_d = ST_TICK;
				end else if (step_q + 8'd1 >= lq_eff) begin
					state_d = ST_TICK;
				end else begin
					in_low_d = 1'b1; scan_d = '0;
					state_d = ST_ADM_RD;
				end
			end
			ST_OUT_RD: begin
				wra = scan_q;
				req.rd_en = 1'b1; req.rd_addr = scan_q;
				state_d = ST_OUT_EMIT;
			end
			ST_OUT_EMIT: begin
				result_valid = 1'b1;
				if (last_scan) begin
					// batch done, back to an empty load state
					clr_batch   = 1'b1;
					clock_d     = '0;
					done_d      = '0;
					run_high_d  = '0;
					run_low_d   = '0;
					high_pend_d = 1'b0;
					low_pend_d  = 1'b0;
					step_d      = '0;
					state_d     = ST_LOAD;
				end else begin
					scan_d = scan_q + idx_t'(1);
					state_d = ST_OUT_RD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
		fclr = clr_batch;
	end

	// results
	assign process_index   = 6'(scan_q);
	assign wait_time       = wrd;
	assign turnaround_time = TimeW'(rd.burst) + wrd;
	assign last_result     = last_scan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			hq_q        <= HighQuantumRst;
			lq_q        <= LowQuantumRst;
			load_cnt_q  <= '0;
			done_cnt_q  <= '0;
			clock_q     <= '0;
			mark_q      <= '0;
			scan_q      <= '0;
			run_high_q  <= '0;
			run_low_q   <= '0;
			cur_q       <= '0;
			high_pend_q <= 1'b0;
			low_pend_q  <= 1'b0;
			step_q      <= '0;
			in_low_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			clock_q     <= clock_d;
			done_cnt_q  <= done_d;
			scan_q      <= scan_d;
			run_high_q  <= run_high_d;
			run_low_q   <= run_low_d;
			cur_q       <= cur_d;
			high_pend_q <= high_pend_d;
			low_pend_q  <= low_pend_d;
			step_q      <= step_d;
			in_low_q    <= in_low_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CfgHighQuantum) hq_q <= cfg_data;
				else lq_q <= cfg_data;
			end
			if (clr_batch) begin
				load_cnt_q <= '0;
			end else if (load_fire && load_cnt_q != cnt_t'(MaxProcs)) begin
				load_cnt_q <= load_cnt_q + cnt_t'(1);
			end
			if (clr_batch) begin
				mark_q <= '0;
			end else if (mark_d_set) begin
				mark_q[scan_q] <= 1'b1;
			end
		end
	end

	// the completed count never passes the loaded count
	assert property (@(posedge clk) disable iff (!arst_n) done_cnt_q <= load_cnt_q)
		else $error("done count exceeds load count");

	// results only come while busy, never in the load state
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> state_q == ST_OUT_EMIT)
		else $error("result outside emit state");

	// a result ending the batch returns to loading
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_result) |=> state_q == ST_LOAD)
		else $error("batch not closed after last result");

endmodule

FILE: design/tlqs_proc_mem.sv
// ----------------------------------------------------------------------------
// tlqs_proc_mem
// process table memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module tlqs_proc_mem (
	input  logic               clk,
	input  tlqs_pkg::mem_req_t req,
	output tlqs_pkg::proc_t    rd_data
);
	import tlqs_pkg::*;

	proc_t mem [MaxProcs];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

FILE: design/tlqs_wait_mem.sv
// ----------------------------------------------------------------------------
// tlqs_wait_mem
// waiting time memory, written on completion, read while results go out
// ----------------------------------------------------------------------------
module tlqs_wait_mem (
	input  logic                       clk,
	input  logic                       wr_en,
	input  tlqs_pkg::idx_t             wr_addr,
	input  logic [tlqs_pkg::TimeW-1:0] wr_data,
	input  tlqs_pkg::idx_t             rd_addr,
	output logic [tlqs_pkg::TimeW-1:0] rd_data
);
	import tlqs_pkg::*;

	logic [TimeW-1:0] mem [MaxProcs];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: design/tlqs_fifo.sv
// ----------------------------------------------------------------------------
// tlqs_fifo
// small circular queue of process indexes
// ----------------------------------------------------------------------------
module tlqs_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clr,
	input  logic           push,
	input  tlqs_pkg::idx_t push_idx,
	input  logic           pop,
	output tlqs_pkg::idx_t head_idx,
	output logic           not_empty
);
	import tlqs_pkg::*;

	idx_t slot_q [MaxProcs];
	idx_t head_q;
	cnt_t count_q;
	idx_t tail;

	assign tail      = head_q + count_q[IdxW-1:0];
	assign head_idx  = slot_q[head_q];
	assign not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push && count_q != cnt_t'(MaxProcs)) begin
			slot_q[tail] <= push_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (clr) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (push && count_q != cnt_t'(MaxProcs)) begin
			count_q <= count_q + cnt_t'(1);
		end else if (pop) begin
			head_q  <= head_q + idx_t'(1);
			count_q <= count_q - cnt_t'(1);
		end
	end

endmodule
